/* rtl/abst_pkg.sv */
// ----------------------------------------------------------------------------
// abst_pkg
// Shared constants for the array-backed binary search tree engine: field
// widths, operation codes and result status codes.
// ----------------------------------------------------------------------------
package abst_pkg;

  localparam int KEY_WIDTH    = 32;
  localparam int SIZE_DEF     = 256;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int SLOT_W       = 8;
  localparam int COUNT_W      = 9;
  localparam int OUT_DATA_W   = 24;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd3;

endpackage

/* rtl/abst_ram.sv */
// ----------------------------------------------------------------------------
// abst_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module abst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = abst_pkg::SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/array_bst_engine_core.sv */
// ----------------------------------------------------------------------------
// array_bst_engine_core
// Binary search tree in slot memories, root at slot 0, with a free-slot
// stack. Each item inserts, finds or removes one signed key.
// ----------------------------------------------------------------------------
// Each item walks the tree one level per node-memory read, between set-up
// and write-back states; a degenerate tree gives the longest walk.
// Throughput: one item at a time; the next item is taken once the result has
// been moved to the output register. The walk pace is set by the registered
// read of the node memory, needed at every level.
// Reset clears the node count and the stack high-water mark; no memory sweep.
module array_bst_engine_core #(
  parameter int SIZE = abst_pkg::SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [abst_pkg::KEY_WIDTH-1:0]    in_tdata,  // key
  input  logic [abst_pkg::KIND_W-1:0]       in_tuser,  // kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [abst_pkg::OUT_DATA_W-1:0]   out_tdata, // slot, node_count, zero fill
  output logic [abst_pkg::STATUS_W-1:0]     out_tuser  // status
);

  localparam int KW     = abst_pkg::KEY_WIDTH;
  localparam int AW     = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int LW     = $clog2(SIZE + 1);
  localparam int NODE_W = KW + 2 * LW;
  localparam logic [LW-1:0] NIL = LW'(SIZE);

  typedef struct packed {
    logic [LW-1:0] rl;
    logic [LW-1:0] ll;
    logic [KW-1:0] key;
  } node_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_POP, S_INS, S_LOC, S_SUCC, S_DET, S_PCLR,
    S_COPY, S_CCLR, S_PUSH, S_KEYW, S_RES
  } state_t;

  state_t st_r, st_nxt;
  logic [abst_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [KW-1:0]                 key_r, key_nxt, sk_r, sk_nxt;
  logic [AW-1:0]                 cur_r, cur_nxt, n_r, n_nxt, slot_r, slot_nxt;
  logic [AW-1:0]                 det_t_r, det_t_nxt, push_r, push_nxt;
  logic [LW-1:0]                 par_r, par_nxt, det_c_r, det_c_nxt;
  logic                          via_r, via_nxt, two_r, two_nxt;
  logic [LW-1:0]                 nc_r, nc_nxt, hwm_r, hwm_nxt;
  logic [abst_pkg::STATUS_W-1:0] res_st_r, res_st_nxt;
  logic                          ov_r, ov_nxt;
  logic [abst_pkg::STATUS_W-1:0] os_r, os_nxt;
  logic [abst_pkg::SLOT_W-1:0]   oslot_r, oslot_nxt;
  logic [abst_pkg::COUNT_W-1:0]  ocnt_r, ocnt_nxt;

  logic          nd_we, fs_we;
  logic [AW-1:0] nd_waddr, nd_raddr, fs_waddr, fs_raddr;
  node_t         nd_wdata, nd_rd;
  logic [NODE_W-1:0] nd_rdata;
  logic [AW-1:0] fs_wdata, fs_rd;
  logic          go_left;
  logic [LW-1:0] nxt_link;

  abst_ram #(.WIDTH(NODE_W), .DEPTH(SIZE)) u_node_ram (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
    .raddr(nd_raddr), .rdata(nd_rdata)
  );

  abst_ram #(.WIDTH(AW), .DEPTH(SIZE)) u_free_ram (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rd)
  );

  assign nd_rd     = node_t'(nd_rdata);
  assign go_left   = nd_rd.key > key_r;
  assign nxt_link  = go_left ? nd_rd.ll : nd_rd.rl;
  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tuser  = os_r;
  assign out_tdata  = {(abst_pkg::OUT_DATA_W - abst_pkg::COUNT_W - abst_pkg::SLOT_W)'(0),
                       ocnt_r, oslot_r};

  always_comb begin
    st_nxt = st_r;       kind_nxt = kind_r;   key_nxt = key_r;   sk_nxt = sk_r;
    cur_nxt = cur_r;     n_nxt = n_r;         slot_nxt = slot_r; det_t_nxt = det_t_r;
    push_nxt = push_r;   par_nxt = par_r;     det_c_nxt = det_c_r;
    via_nxt = via_r;     two_nxt = two_r;     nc_nxt = nc_r;     hwm_nxt = hwm_r;
    res_st_nxt = res_st_r;
    ov_nxt = ov_r & ~out_tready;
    os_nxt = os_r;       oslot_nxt = oslot_r; ocnt_nxt = ocnt_r;
    nd_we = 1'b0;  nd_waddr = '0;  nd_wdata = nd_rd;  nd_raddr = '0;
    fs_we = 1'b0;  fs_waddr = '0;  fs_wdata = push_r;
    fs_raddr = AW'(SIZE - 1) - nc_r[AW-1:0];
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt = in_tuser;
          key_nxt  = in_tdata ^ {1'b1, (KW-1)'(0)};
          slot_nxt = '0;
          two_nxt  = 1'b0;
          st_nxt   = S_START;
        end
      end
      S_START: begin
        cur_nxt = '0;
        par_nxt = NIL;
        via_nxt = 1'b0;
        st_nxt  = S_RES;
        unique case (kind_r) inside
          abst_pkg::KIND_INSERT: begin
            if (nc_r == LW'(SIZE)) begin
              res_st_nxt = abst_pkg::ST_FULL;
            end else begin
              st_nxt = S_POP;
            end
          end
          abst_pkg::KIND_FIND, abst_pkg::KIND_REMOVE: begin
            if (nc_r == '0) begin
              res_st_nxt = abst_pkg::ST_NOTFOUND;
            end else begin
              st_nxt = S_LOC;
            end
          end
          default: res_st_nxt = abst_pkg::ST_DONE;
        endcase
      end
      S_POP: begin
        slot_nxt = (nc_r < hwm_r) ? fs_rd : nc_r[AW-1:0];
        nd_we    = 1'b1;
        nd_waddr = slot_nxt;
        nd_wdata = '{rl: NIL, ll: NIL, key: key_r};
        nc_nxt   = nc_r + LW'(1);
        if (nc_r == hwm_r) begin
          hwm_nxt = hwm_r + LW'(1);
        end
        res_st_nxt = abst_pkg::ST_DONE;
        st_nxt   = (slot_nxt == '0) ? S_RES : S_INS;
      end
      S_INS: begin
        if (nxt_link == NIL) begin
          nd_we    = 1'b1;
          nd_waddr = cur_r;
          if (go_left) begin
            nd_wdata.ll = LW'(slot_r);
          end else begin
            nd_wdata.rl = LW'(slot_r);
          end
          st_nxt = S_RES;
        end else begin
          cur_nxt  = nxt_link[AW-1:0];
          nd_raddr = cur_nxt;
        end
      end
      S_LOC: begin
        if (nd_rd.key == key_r) begin
          n_nxt = cur_r;
          res_st_nxt = abst_pkg::ST_DONE;
          if (kind_r == abst_pkg::KIND_FIND) begin
            res_st_nxt = abst_pkg::ST_FOUND;
            slot_nxt   = cur_r;
            st_nxt     = S_RES;
          end else if (nd_rd.ll != NIL && nd_rd.rl != NIL) begin
            par_nxt  = LW'(cur_r);
            via_nxt  = 1'b0;
            cur_nxt  = nd_rd.rl[AW-1:0];
            nd_raddr = cur_nxt;
            st_nxt   = S_SUCC;
          end else begin
            det_t_nxt = cur_r;
            det_c_nxt = (nd_rd.ll != NIL) ? nd_rd.ll : nd_rd.rl;
            st_nxt    = S_DET;
          end
        end else if (nxt_link == NIL) begin
          res_st_nxt = abst_pkg::ST_NOTFOUND;
          st_nxt     = S_RES;
        end else begin
          par_nxt  = LW'(cur_r);
          via_nxt  = go_left;
          cur_nxt  = nxt_link[AW-1:0];
          nd_raddr = cur_nxt;
        end
      end
      S_SUCC: begin
        if (nd_rd.ll != NIL) begin
          par_nxt  = LW'(cur_r);
          via_nxt  = 1'b1;
          cur_nxt  = nd_rd.ll[AW-1:0];
          nd_raddr = cur_nxt;
        end else begin
          sk_nxt    = nd_rd.key;
          two_nxt   = 1'b1;
          det_t_nxt = cur_r;
          det_c_nxt = nd_rd.rl;
          st_nxt    = S_DET;
        end
      end
      S_DET: begin
        push_nxt = det_t_r;
        if (det_c_r != NIL) begin
          nd_raddr = det_c_r[AW-1:0];
          st_nxt   = S_COPY;
        end else if (par_r != NIL) begin
          nd_raddr = par_r[AW-1:0];
          st_nxt   = S_PCLR;
        end else begin
          st_nxt = S_PUSH;
        end
      end
      S_PCLR: begin
        nd_we    = 1'b1;
        nd_waddr = par_r[AW-1:0];
        if (via_r) begin
          nd_wdata.ll = NIL;
        end else begin
          nd_wdata.rl = NIL;
        end
        st_nxt = S_PUSH;
      end
      S_COPY: begin
        nd_we    = 1'b1;
        nd_waddr = det_t_r;
        push_nxt = det_c_r[AW-1:0];
        st_nxt   = S_CCLR;
      end
      S_CCLR: begin
        nd_we    = 1'b1;
        nd_waddr = det_c_r[AW-1:0];
        nd_wdata = '{rl: NIL, ll: NIL, key: key_r};
        st_nxt   = S_PUSH;
      end
      S_PUSH: begin
        fs_we    = 1'b1;
        fs_waddr = AW'(LW'(SIZE) - nc_r);
        nc_nxt   = nc_r - LW'(1);
        res_st_nxt = abst_pkg::ST_DONE;
        nd_raddr = n_r;
        st_nxt   = two_r ? S_KEYW : S_RES;
      end
      S_KEYW: begin
        nd_we        = 1'b1;
        nd_waddr     = n_r;
        nd_wdata.key = sk_r;
        st_nxt       = S_RES;
      end
      S_RES: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          os_nxt    = res_st_r;
          oslot_nxt = abst_pkg::SLOT_W'(slot_r);
          ocnt_nxt  = abst_pkg::COUNT_W'(nc_r);
          st_nxt    = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      nc_r  <= '0;
      hwm_r <= '0;
      ov_r  <= 1'b0;
      two_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      nc_r  <= nc_nxt;
      hwm_r <= hwm_nxt;
      ov_r  <= ov_nxt;
      two_r <= two_nxt;
    end
    kind_r <= kind_nxt;   key_r <= key_nxt;     sk_r <= sk_nxt;
    cur_r <= cur_nxt;     n_r <= n_nxt;         slot_r <= slot_nxt;
    det_t_r <= det_t_nxt; push_r <= push_nxt;   par_r <= par_nxt;
    det_c_r <= det_c_nxt; via_r <= via_nxt;     res_st_r <= res_st_nxt;
    os_r <= os_nxt;       oslot_r <= oslot_nxt; ocnt_r <= ocnt_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) nc_r <= LW'(SIZE))
    else $error("node count above capacity");
  assert property (@(posedge clk) disable iff (!rst_n) hwm_r >= nc_r)
    else $error("stack high-water mark below node count");
  assert property (@(posedge clk) disable iff (!rst_n) (st_r == S_PUSH) |-> (nc_r != '0))
    else $error("slot freed with an empty tree");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == abst_pkg::ST_FULL) |-> (ocnt_r == abst_pkg::COUNT_W'(SIZE)))
    else $error("tree full reported below capacity");

endmodule
